>>> rtl/core/sbc_pkg.sv
package sbc_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * COORD_BITS;
    localparam int REM_W      = COORD_BITS + FRAC_BITS + 2;
    localparam int DIV_STAGES = FRAC_BITS + 1;

    typedef logic signed [COORD_BITS:0] wide_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] box_left;
        logic signed [COORD_BITS-1:0] box_bottom;
        logic signed [COORD_BITS-1:0] box_right;
        logic signed [COORD_BITS-1:0] box_top;
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } seg_word_t;

    typedef struct packed {
        logic                 hit;
        logic [FRAC_BITS:0]   entry_part;
        logic [FRAC_BITS:0]   exit_part;
    } res_word_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] num;
        logic [COORD_BITS-1:0] den;
    } frac_t;

    typedef struct packed {
        logic  hit;
        logic  point;
        frac_t tin;
        frac_t tout;
    } geom_t;

    typedef struct packed {
        logic [REM_W-1:0]      rem;
        logic [COORD_BITS-1:0] den;
        logic [FRAC_BITS:0]    q;
    } div_lane_t;

    localparam frac_t FRAC_ZERO = '{num: '0, den: COORD_BITS'(1)};
    localparam frac_t FRAC_ONE  = '{num: COORD_BITS'(1), den: COORD_BITS'(1)};
    localparam logic [FRAC_BITS:0] Q_ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

    function automatic wide_t sx(input logic [COORD_BITS-1:0] v);
        return wide_t'({v[COORD_BITS-1], v});
    endfunction

    // line parameter where the line reaches an edge, clamped to [0,1]
    function automatic frac_t cross_at(input wide_t n_in, input wide_t d_in);
        wide_t n;
        wide_t d;
        frac_t r;
        n = d_in < 0 ? -n_in : n_in;
        d = d_in < 0 ? -d_in : d_in;
        if (n <= 0)
            r = FRAC_ZERO;
        else if (n >= d)
            r = FRAC_ONE;
        else
        begin
            r.num = n[COORD_BITS-1:0];
            r.den = d[COORD_BITS-1:0];
        end
        return r;
    endfunction

    function automatic logic frac_le(input frac_t x, input frac_t y);
        logic [PROD_W-1:0] p1;
        logic [PROD_W-1:0] p2;
        p1 = PROD_W'(x.num) * PROD_W'(y.den);
        p2 = PROD_W'(y.num) * PROD_W'(x.den);
        return p1 <= p2;
    endfunction

endpackage

>>> rtl/core/sbc_front.sv
module sbc_front
    import sbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      seg_valid,
    input  seg_word_t seg,
    output logic      geom_valid,
    output geom_t     geom
);

    logic  v1_reg, v2_reg, v3_reg, v4_reg;
    logic  kill1_reg, kill2_reg, kill3_reg;
    logic  point1_reg, point2_reg, point3_reg;
    frac_t xu1_reg, xv1_reg, yu1_reg, yv1_reg;
    frac_t x0_2_reg, x1_2_reg, y0_2_reg, y1_2_reg;
    frac_t tin3_reg, tout3_reg;
    geom_t geom_reg;

    wide_t left, bottom, right, top, ax, ay, bx, by, dx, dy;
    frac_t xu_next, xv_next, yu_next, yv_next;
    logic  kill_next, point_next, xmiss, ymiss, flat;
    logic  xle, yle;
    geom_t geom_next;

    always_comb
    begin
        left   = sx(seg.box_left);
        bottom = sx(seg.box_bottom);
        right  = sx(seg.box_right);
        top    = sx(seg.box_top);
        ax     = sx(seg.start_x);
        ay     = sx(seg.start_y);
        bx     = sx(seg.end_x);
        by     = sx(seg.end_y);
        dx     = bx - ax;
        dy     = by - ay;
        xu_next = (dx == 0) ? FRAC_ZERO : cross_at(left - ax, dx);
        xv_next = (dx == 0) ? FRAC_ONE  : cross_at(right - ax, dx);
        yu_next = (dy == 0) ? FRAC_ZERO : cross_at(bottom - ay, dy);
        yv_next = (dy == 0) ? FRAC_ONE  : cross_at(top - ay, dy);
        flat  = (dx == 0 && (ax == left || ax == right)) ||
                (dy == 0 && (ay == bottom || ay == top)) ||
                left > right || bottom > top;
        xmiss = dx == 0 && !(ax >= left && ax <= right);
        ymiss = dy == 0 && !(ay >= bottom && ay <= top);
        kill_next  = flat || xmiss || ymiss;
        point_next = dx == 0 && dy == 0;
    end

    assign xle = frac_le(xu1_reg, xv1_reg);
    assign yle = frac_le(yu1_reg, yv1_reg);

    always_comb
    begin
        geom_next.hit   = !kill3_reg && frac_le(tin3_reg, tout3_reg);
        geom_next.point = point3_reg;
        geom_next.tin   = tin3_reg;
        geom_next.tout  = tout3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg <= seg_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            kill1_reg  <= kill_next;
            point1_reg <= point_next;
            xu1_reg    <= xu_next;
            xv1_reg    <= xv_next;
            yu1_reg    <= yu_next;
            yv1_reg    <= yv_next;

            kill2_reg  <= kill1_reg;
            point2_reg <= point1_reg;
            x0_2_reg   <= xle ? xu1_reg : xv1_reg;
            x1_2_reg   <= xle ? xv1_reg : xu1_reg;
            y0_2_reg   <= yle ? yu1_reg : yv1_reg;
            y1_2_reg   <= yle ? yv1_reg : yu1_reg;

            kill3_reg  <= kill2_reg;
            point3_reg <= point2_reg;
            tin3_reg   <= frac_le(y0_2_reg, x0_2_reg) ? x0_2_reg : y0_2_reg;
            tout3_reg  <= frac_le(x1_2_reg, y1_2_reg) ? x1_2_reg : y1_2_reg;

            geom_reg   <= geom_next;
        end
    end

    assign geom_valid = v4_reg;
    assign geom       = geom_reg;

endmodule

>>> rtl/core/sbc_quant.sv
module sbc_quant
    import sbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      advance,
    input  logic      geom_valid,
    input  geom_t     geom,
    output logic      res_valid,
    output res_word_t res
);

    div_lane_t lane_reg [0:DIV_STAGES][0:1];
    logic      valid_reg [0:DIV_STAGES];
    logic      hit_reg [0:DIV_STAGES];

    frac_t     src [0:1];
    div_lane_t lane_in [0:1];
    div_lane_t lane_next [0:DIV_STAGES-1][0:1];

    always_comb
    begin
        src[0] = (geom.hit && !geom.point) ? geom.tin  : FRAC_ZERO;
        src[1] = (geom.hit && !geom.point) ? geom.tout : FRAC_ZERO;
        for (int j = 0; j < 2; j++)
        begin
            lane_in[j].rem = (REM_W'(src[j].num) << (FRAC_BITS + 1)) + REM_W'(src[j].den);
            lane_in[j].den = src[j].den;
            lane_in[j].q   = '0;
        end
    end

    for (genvar k = 0; k < DIV_STAGES; k++)
    begin : g_step
        for (genvar j = 0; j < 2; j++)
        begin : g_lane
            logic [REM_W-1:0] dsh;
            always_comb
            begin
                dsh = REM_W'({lane_reg[k][j].den, 1'b0}) << (FRAC_BITS - k);
                lane_next[k][j] = lane_reg[k][j];
                if (lane_reg[k][j].rem >= dsh)
                begin
                    lane_next[k][j].rem = lane_reg[k][j].rem - dsh;
                    lane_next[k][j].q[FRAC_BITS-k] = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= DIV_STAGES; k++)
                valid_reg[k] <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg[0] <= geom_valid;
            for (int k = 0; k < DIV_STAGES; k++)
                valid_reg[k+1] <= valid_reg[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            hit_reg[0]  <= geom.hit;
            lane_reg[0] <= lane_in;
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                hit_reg[k+1]  <= hit_reg[k];
                lane_reg[k+1] <= lane_next[k];
            end
        end
    end

    always_comb
    begin
        res.hit        = hit_reg[DIV_STAGES];
        res.entry_part = (lane_reg[DIV_STAGES][0].q > Q_ONE) ? Q_ONE
                                                             : lane_reg[DIV_STAGES][0].q;
        res.exit_part  = (lane_reg[DIV_STAGES][1].q > Q_ONE) ? Q_ONE
                                                             : lane_reg[DIV_STAGES][1].q;
    end

    assign res_valid = valid_reg[DIV_STAGES];

endmodule

>>> rtl/core/segment_box_clip.sv
// Segment versus box test: one word in per cycle unless stalled, one result
// word out per word, in order. Four geometry stages (slab crossings, per-axis
// ordering, entry/exit select, hit test), an input register, then a restoring
// divider of FRAC_BITS + 1 stages, one quotient bit each, that rounds both
// fractions; its last stage is the output register. A stall on the result side,
// with res_valid high, freezes the whole pipeline and shows as seg_stall.
module segment_box_clip
    import sbc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      seg_valid,
    output logic      seg_stall,
    input  seg_word_t seg,
    output logic      res_valid,
    input  logic      res_stall,
    output res_word_t res
);

    logic  advance;
    logic  geom_valid;
    geom_t geom;

    assign advance   = !(res_valid && res_stall);
    assign seg_stall = !advance;

    sbc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .seg_valid  (seg_valid),
        .seg        (seg),
        .geom_valid (geom_valid),
        .geom       (geom)
    );

    sbc_quant u_quant (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .geom_valid (geom_valid),
        .geom       (geom),
        .res_valid  (res_valid),
        .res        (res)
    );

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.hit |-> res.entry_part == '0 && res.exit_part == '0)
        else $error("miss with nonzero fraction");

    a_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.entry_part <= res.exit_part)
        else $error("entry past exit");

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.exit_part <= Q_ONE)
        else $error("fraction above one");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        seg_stall == (res_valid && res_stall))
        else $error("stall not tied to output hold");

endmodule

>>> test/tb_segment_box_clip.sv
`timescale 1ns / 1ps

module tb_segment_box_clip;
    import sbc_pkg::*;

    logic      clk;
    logic      rst_n;
    logic      seg_valid;
    logic      seg_stall;
    seg_word_t seg;
    logic      res_valid;
    logic      res_stall = 1'b0;
    res_word_t res;

    res_word_t clip_expected[$];
    int        error_count = 0;

    segment_box_clip dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        #50ms;
        $display("Verification failed");
        $finish;
    end

    // exact fraction, n/d with 0 <= n <= d
    typedef struct {
        longint n;
        longint d;
    } ratio_t;

    function automatic int ratio_cmp(ratio_t x, ratio_t y);
        longint p1;
        longint p2;
        p1 = x.n * y.d;
        p2 = y.n * x.d;
        return (p1 < p2) ? -1 : ((p1 > p2) ? 1 : 0);
    endfunction

    function automatic ratio_t edge_param(longint edge_pos, longint a, longint delta);
        ratio_t r;
        longint n;
        longint d;
        n = edge_pos - a;
        d = delta;
        if (d < 0)
        begin
            n = -n;
            d = -d;
        end
        if (n <= 0)
            r = '{0, 1};
        else if (n >= d)
            r = '{1, 1};
        else
            r = '{n, d};
        return r;
    endfunction

    function automatic bit slab_span(longint lo, longint hi, longint a, longint b,
                                     output ratio_t t0, output ratio_t t1);
        ratio_t u;
        ratio_t v;
        t0 = '{0, 1};
        t1 = '{1, 1};
        if (a == b)
            return a >= lo && a <= hi;
        u = edge_param(lo, a, b - a);
        v = edge_param(hi, a, b - a);
        if (ratio_cmp(u, v) <= 0)
        begin
            t0 = u;
            t1 = v;
        end
        else
        begin
            t0 = v;
            t1 = u;
        end
        return 1'b1;
    endfunction

    function automatic logic [FRAC_BITS:0] to_q16(ratio_t f);
        longint q;
        q = ((f.n << (FRAC_BITS + 1)) + f.d) / (f.d * 2);
        if (q > (longint'(1) << FRAC_BITS))
            q = longint'(1) << FRAC_BITS;
        return q[FRAC_BITS:0];
    endfunction

    function automatic res_word_t clip_segment(seg_word_t s);
        res_word_t r;
        longint    l, bt, rt, tp, ax, ay, bx, by;
        ratio_t    x0, x1, y0, y1, tin, tout;
        r = '0;
        l = s.box_left;
        bt = s.box_bottom;
        rt = s.box_right;
        tp = s.box_top;
        ax = s.start_x;
        ay = s.start_y;
        bx = s.end_x;
        by = s.end_y;
        if (ax == bx && (ax == l || ax == rt))
            return r;
        if (ay == by && (ay == bt || ay == tp))
            return r;
        if (l > rt || bt > tp)
            return r;
        if (!slab_span(l, rt, ax, bx, x0, x1))
            return r;
        if (!slab_span(bt, tp, ay, by, y0, y1))
            return r;
        tin = ratio_cmp(x0, y0) >= 0 ? x0 : y0;
        tout = ratio_cmp(x1, y1) <= 0 ? x1 : y1;
        if (ratio_cmp(tin, tout) > 0)
            return r;
        r.hit = 1'b1;
        if (ax == bx && ay == by)
            return r;
        r.entry_part = to_q16(tin);
        r.exit_part = to_q16(tout);
        return r;
    endfunction

    task automatic send_segment(seg_word_t s);
        int gap;
        gap = $urandom_range(0, 18);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap != 0)
        begin
            seg_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        seg_valid <= 1'b1;
        seg <= s;
        @(posedge clk);
        while (seg_stall)
            @(posedge clk);
        clip_expected.push_back(clip_segment(s));
    endtask

    function automatic seg_word_t make_seg(int l, int b, int r, int t,
                                           int ax, int ay, int bx, int by);
        seg_word_t s;
        s.box_left = 16'(l);
        s.box_bottom = 16'(b);
        s.box_right = 16'(r);
        s.box_top = 16'(t);
        s.start_x = 16'(ax);
        s.start_y = 16'(ay);
        s.end_x = 16'(bx);
        s.end_y = 16'(by);
        return s;
    endfunction

    function automatic logic [15:0] rand_coord(int span);
        if ($urandom_range(0, 3) == 0)
            return 16'($urandom);
        return 16'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    task automatic test_directed();
        send_segment(make_seg(-10, -10, 10, 10, -20, 0, 20, 0));
        send_segment(make_seg(-10, -10, 10, 10, -20, -20, 20, 20));
        send_segment(make_seg(-10, -10, 10, 10, 10, -20, 10, 20));
        send_segment(make_seg(-10, -10, 10, 10, -20, -10, 20, -10));
        send_segment(make_seg(-10, -10, 10, 10, -10, -20, -10, 20));
        send_segment(make_seg(-10, -10, 10, 10, -20, 10, 20, 10));
        send_segment(make_seg(10, -10, -10, 10, -20, 0, 20, 0));
        send_segment(make_seg(-10, 10, 10, -10, -20, 0, 20, 0));
        send_segment(make_seg(-10, -10, 10, 10, 3, 4, 3, 4));
        send_segment(make_seg(-10, -10, 10, 10, 10, 10, 10, 10));
        send_segment(make_seg(-10, -10, 10, 10, 30, 4, 30, 4));
        send_segment(make_seg(-10, -10, 10, 10, 5, -30, 5, 30));
        send_segment(make_seg(-10, -10, 10, 10, 20, 0, -20, 0));
        send_segment(make_seg(-10, -10, 10, 10, -20, 30, 30, -20));
        send_segment(make_seg(-10, -10, 10, 10, 0, 0, 1, 1));
        send_segment(make_seg(-10, -10, 10, 10, 20, 20, 30, 30));
        send_segment(make_seg(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767));
        send_segment(make_seg(-32768, -32768, 32767, 32767, 32767, -32768, -32768, 32767));
        send_segment(make_seg(-100, -100, 100, 100, -32768, 1, 32767, 2));
        send_segment(make_seg(0, 0, 0, 0, -5, -5, 5, 5));
        send_segment(make_seg(-1, -1, 1, 1, -32768, 0, 32767, 0));
        send_segment(make_seg(-10, -10, 10, 10, -11, 0, 11, 1));
        send_segment(make_seg(32767, 32767, -32768, -32768, 0, 0, 1, 1));
    endtask

    task automatic test_random(int count);
        seg_word_t s;
        int        span;
        logic [15:0] a, b;
        repeat (count)
        begin
            span = ($urandom_range(0, 7) == 0) ? 32767 : 200;
            a = rand_coord(span);
            b = rand_coord(span);
            if ($urandom_range(0, 4) != 0 && $signed(a) > $signed(b))
                {a, b} = {b, a};
            s.box_left = a;
            s.box_right = b;
            a = rand_coord(span);
            b = rand_coord(span);
            if ($urandom_range(0, 4) != 0 && $signed(a) > $signed(b))
                {a, b} = {b, a};
            s.box_bottom = a;
            s.box_top = b;
            s.start_x = rand_coord(span);
            s.start_y = rand_coord(span);
            s.end_x = rand_coord(span);
            s.end_y = rand_coord(span);
            case ($urandom_range(0, 9))
                0: s.end_x = s.start_x;
                1: s.end_y = s.start_y;
                2: s.end_x = ($urandom_range(0, 1)) ? s.box_left : s.box_right;
                3: s.start_y = ($urandom_range(0, 1)) ? s.box_bottom : s.box_top;
                4:
                begin
                    s.end_x = s.start_x;
                    s.end_y = s.start_y;
                end
                default: ;
            endcase
            send_segment(s);
        end
    endtask

    task automatic wait_drained();
        seg_valid <= 1'b0;
        while (clip_expected.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stall and checking
    always @(posedge clk)
    begin
        res_word_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (clip_expected.size() == 0)
            begin
                $display("%0t: unexpected word %h", $time, res);
                error_count++;
            end
            else
            begin
                want = clip_expected.pop_front();
                if (res.hit !== want.hit)
                begin
                    $display("%0t: hit expected %0d actual %0d", $time, want.hit, res.hit);
                    error_count++;
                end
                if (res.entry_part !== want.entry_part)
                begin
                    $display("%0t: entry_part expected %0d actual %0d",
                             $time, want.entry_part, res.entry_part);
                    error_count++;
                end
                if (res.exit_part !== want.exit_part)
                begin
                    $display("%0t: exit_part expected %0d actual %0d",
                             $time, want.exit_part, res.exit_part);
                    error_count++;
                end
            end
        end
    end

    int stall_left = 0;
    bit stall_quiet;
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_stall <= 1'b1;
        end
        else if (!stall_quiet && $urandom_range(0, 3) == 0)
        begin
            stall_left <= $urandom_range(0, 18);
            res_stall <= 1'b1;
        end
        else
            res_stall <= 1'b0;
    end

    initial
    begin
        int cycles;
        rst_n = 1'b0;
        seg_valid = 1'b0;
        seg = '0;
        stall_quiet = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        wait_drained();
        test_random(600);
        stall_quiet = 1'b1;
        test_random(50);
        stall_quiet = 1'b0;
        test_random(600);
        wait_drained();
        cycles = 0;
        while (clip_expected.size() != 0 && cycles < 100000)
        begin
            @(posedge clk);
            cycles++;
        end
        repeat (40) @(posedge clk);
        if (error_count == 0 && clip_expected.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

>>> sim.f
rtl/core/sbc_pkg.sv
rtl/core/sbc_front.sv
rtl/core/sbc_quant.sv
rtl/core/segment_box_clip.sv
test/tb_segment_box_clip.sv
